FILE: src/lphs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lphs_pkg
// Shared constants, codes and port structs of the linear probe hash set.
// ----------------------------------------------------------------------------
package lphs_pkg;

    localparam int TABLE_SLOTS   = 26;
    localparam int MAX_KEY_BYTES = 8;

    localparam int KEY_BYTES = 8;
    localparam int KEY_W     = 8 * KEY_BYTES;
    localparam int LEN_W     = 4;
    localparam int STATUS_W  = 3;
    localparam int SLOT_OUT_W = 5;
    localparam int SLOT_W    = $clog2(TABLE_SLOTS);
    localparam int CNT_W     = $clog2(TABLE_SLOTS + 1);

    localparam logic [7:0] CHAR_A = 8'h61;
    localparam logic [7:0] CHAR_Z = 8'h7a;

    typedef enum logic [1:0] {
        MARK_NEVER    = 2'd0,
        MARK_OCCUPIED = 2'd1,
        MARK_TOMB     = 2'd2
    } mark_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_PRESENT   = 3'd1,
        ST_FULL      = 3'd2,
        ST_DELETED   = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_BAD_KEY   = 3'd5
    } status_t;

    localparam logic MODE_ADD = 1'b0;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] slot;
    } rd_req_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [LEN_W-1:0] len;
        mark_t            mark;
    } rd_data_t;

    typedef struct packed {
        logic              en;
        logic              key_en;
        logic [SLOT_W-1:0] slot;
        mark_t             mark;
        logic [KEY_W-1:0]  key;
        logic [LEN_W-1:0]  len;
    } wr_req_t;

endpackage

FILE: src/lphs_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lphs_req_if
// Request channel: add or delete one key per beat.
// ----------------------------------------------------------------------------
interface lphs_req_if;
    logic                       valid;
    logic                       ready;
    logic                       mode;
    logic [lphs_pkg::KEY_W-1:0] key;
    logic [lphs_pkg::LEN_W-1:0] key_length;

    modport source (output valid, output mode, output key, output key_length, input ready);
    modport sink   (input valid, input mode, input key, input key_length, output ready);
endinterface

FILE: src/lphs_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lphs_rsp_if
// Response channel: one status and slot per request beat.
// ----------------------------------------------------------------------------
interface lphs_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [lphs_pkg::STATUS_W-1:0]   status;
    logic [lphs_pkg::SLOT_OUT_W-1:0] slot_index;

    modport source (output valid, output status, output slot_index, input ready);
    modport sink   (input valid, input status, input slot_index, output ready);
endinterface

FILE: src/lphs_slot_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lphs_slot_store
// Slot storage: key and length memory plus per-slot marks, one read port
// with registered data and one write port.
// ----------------------------------------------------------------------------
module lphs_slot_store
(
    input  logic                clk,
    input  logic                rst_n,
    input  lphs_pkg::rd_req_t   rd,
    input  lphs_pkg::wr_req_t   wr,
    output lphs_pkg::rd_data_t  rd_data
);

    logic [lphs_pkg::KEY_W-1:0] key_mem [lphs_pkg::TABLE_SLOTS];
    logic [lphs_pkg::LEN_W-1:0] len_mem [lphs_pkg::TABLE_SLOTS];
    lphs_pkg::mark_t            mark_reg [lphs_pkg::TABLE_SLOTS];

    logic [lphs_pkg::KEY_W-1:0] rd_key_reg;
    logic [lphs_pkg::LEN_W-1:0] rd_len_reg;
    lphs_pkg::mark_t            rd_mark_reg;

    // Key memory: no reset, an entry is used only once its mark says occupied
    always_ff @(posedge clk)
    begin
        if (wr.en && wr.key_en)
        begin
            key_mem[wr.slot] <= wr.key;
            len_mem[wr.slot] <= wr.len;
        end
        if (rd.en)
        begin
            rd_key_reg <= key_mem[rd.slot];
            rd_len_reg <= len_mem[rd.slot];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < lphs_pkg::TABLE_SLOTS; i++)
            begin
                mark_reg[i] <= lphs_pkg::MARK_NEVER;
            end
            rd_mark_reg <= lphs_pkg::MARK_NEVER;
        end
        else
        begin
            if (wr.en)
            begin
                mark_reg[wr.slot] <= wr.mark;
            end
            if (rd.en)
            begin
                rd_mark_reg <= mark_reg[rd.slot];
            end
        end
    end

    assign rd_data.key  = rd_key_reg;
    assign rd_data.len  = rd_len_reg;
    assign rd_data.mark = rd_mark_reg;

endmodule

FILE: src/linear_probe_hash_set.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_hash_set
// Open-addressing hash set of short lowercase keys with linear probing.
// ----------------------------------------------------------------------------
// One request at a time: add or delete a key of one to eight characters. The
// home slot is the last character minus 'a'; probing walks the slots in turn
// and wraps. One probe pass serves both the lookup and the choice of a free
// slot for an add. The slot memory has one read port with registered data,
// reads are issued back to back, and a request stops probing at a match, at
// a never-used slot or after a full lap of 26 slots; a bad key is answered
// without probing. A finished response waits in its own register, but the
// next request is not taken until the current one has been handed to that
// register. All slots come out of reset unused.
// ----------------------------------------------------------------------------
module linear_probe_hash_set
(
    input  logic              clk,
    input  logic              rst_n,
    lphs_req_if.sink          req,
    lphs_rsp_if.source        rsp
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PROBE,
        S_DONE
    } state_t;

    state_t                          state_reg, state_next;
    logic                            mode_reg, mode_next;
    logic [lphs_pkg::KEY_W-1:0]      key_reg, key_next;
    logic [lphs_pkg::LEN_W-1:0]      len_reg, len_next;
    logic [lphs_pkg::SLOT_W-1:0]     iss_slot_reg, iss_slot_next;
    logic [lphs_pkg::CNT_W-1:0]      iss_cnt_reg, iss_cnt_next;
    logic                            chk_valid_reg, chk_valid_next;
    logic [lphs_pkg::SLOT_W-1:0]     chk_slot_reg, chk_slot_next;
    logic                            chk_last_reg, chk_last_next;
    logic                            free_hit_reg, free_hit_next;
    logic [lphs_pkg::SLOT_W-1:0]     free_slot_reg, free_slot_next;
    lphs_pkg::status_t               res_status_reg, res_status_next;
    logic [lphs_pkg::SLOT_W-1:0]     res_slot_reg, res_slot_next;
    logic                            out_valid_reg, out_valid_next;
    lphs_pkg::status_t               out_status_reg, out_status_next;
    logic [lphs_pkg::SLOT_W-1:0]     out_slot_reg, out_slot_next;

    lphs_pkg::rd_req_t               rd_req;
    lphs_pkg::wr_req_t               wr_req;
    lphs_pkg::rd_data_t              rd_data;

    logic [lphs_pkg::KEY_W-1:0]      key_masked;
    logic [7:0]                      last_char;
    logic [7:0]                      home_diff;
    logic [lphs_pkg::SLOT_W-1:0]     home_slot;
    logic                            key_bad;

    logic                            slot_match;
    logic                            slot_free;
    logic                            ins_ok;
    logic [lphs_pkg::SLOT_W-1:0]     ins_slot;
    logic [lphs_pkg::SLOT_W-1:0]     iss_slot_succ;

    lphs_slot_store u_store
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd      (rd_req),
        .wr      (wr_req),
        .rd_data (rd_data)
    );

    // Key check and home slot, straight off the request beat
    always_comb
    begin
        key_masked = '0;
        last_char  = '0;
        for (int i = 0; i < lphs_pkg::KEY_BYTES; i++)
        begin
            if ((lphs_pkg::LEN_W'(i) < req.key_length) && (i < lphs_pkg::MAX_KEY_BYTES))
            begin
                key_masked[8*i +: 8] = req.key[8*i +: 8];
            end
            if (lphs_pkg::LEN_W'(i + 1) == req.key_length)
            begin
                last_char = req.key[8*i +: 8];
            end
        end
        key_bad = (req.key_length == '0)
               || (req.key_length > lphs_pkg::LEN_W'(lphs_pkg::MAX_KEY_BYTES))
               || (last_char < lphs_pkg::CHAR_A)
               || (last_char > lphs_pkg::CHAR_Z);
        home_diff = last_char - lphs_pkg::CHAR_A;
        home_slot = (home_diff >= 8'(lphs_pkg::TABLE_SLOTS)) ? '0
                  : home_diff[lphs_pkg::SLOT_W-1:0];
    end

    assign iss_slot_succ = (iss_slot_reg == lphs_pkg::SLOT_W'(lphs_pkg::TABLE_SLOTS - 1))
                         ? '0 : iss_slot_reg + lphs_pkg::SLOT_W'(1);

    assign slot_match = (rd_data.mark == lphs_pkg::MARK_OCCUPIED)
                     && (rd_data.key == key_reg) && (rd_data.len == len_reg);
    assign slot_free  = (rd_data.mark == lphs_pkg::MARK_NEVER)
                     || (rd_data.mark == lphs_pkg::MARK_TOMB);
    assign ins_ok     = free_hit_reg || slot_free;
    assign ins_slot   = free_hit_reg ? free_slot_reg : chk_slot_reg;

    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        key_next        = key_reg;
        len_next        = len_reg;
        iss_slot_next   = iss_slot_reg;
        iss_cnt_next    = iss_cnt_reg;
        chk_valid_next  = chk_valid_reg;
        chk_slot_next   = chk_slot_reg;
        chk_last_next   = chk_last_reg;
        free_hit_next   = free_hit_reg;
        free_slot_next  = free_slot_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;

        rd_req.en     = 1'b0;
        rd_req.slot   = iss_slot_reg;
        wr_req.en     = 1'b0;
        wr_req.key_en = 1'b0;
        wr_req.slot   = chk_slot_reg;
        wr_req.mark   = lphs_pkg::MARK_OCCUPIED;
        wr_req.key    = key_reg;
        wr_req.len    = len_reg;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    mode_next = req.mode;
                    key_next  = key_masked;
                    len_next  = req.key_length;
                    if (key_bad)
                    begin
                        res_status_next = lphs_pkg::ST_BAD_KEY;
                        res_slot_next   = '0;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        iss_slot_next  = home_slot;
                        iss_cnt_next   = '0;
                        chk_valid_next = 1'b0;
                        free_hit_next  = 1'b0;
                        state_next     = S_PROBE;
                    end
                end
            end

            S_PROBE:
            begin
                // Issue the next probe every cycle until a full lap is out
                if (iss_cnt_reg != lphs_pkg::CNT_W'(lphs_pkg::TABLE_SLOTS))
                begin
                    rd_req.en      = 1'b1;
                    iss_slot_next  = iss_slot_succ;
                    iss_cnt_next   = iss_cnt_reg + lphs_pkg::CNT_W'(1);
                    chk_valid_next = 1'b1;
                    chk_slot_next  = iss_slot_reg;
                    chk_last_next  = (iss_cnt_reg
                                   == lphs_pkg::CNT_W'(lphs_pkg::TABLE_SLOTS - 1));
                end
                else
                begin
                    chk_valid_next = 1'b0;
                end

                if (chk_valid_reg)
                begin
                    if (!free_hit_reg && slot_free)
                    begin
                        free_hit_next  = 1'b1;
                        free_slot_next = chk_slot_reg;
                    end

                    priority if (slot_match)
                    begin
                        // Drop the probe still in flight
                        chk_valid_next = 1'b0;
                        state_next     = S_DONE;
                        res_slot_next  = chk_slot_reg;
                        if (mode_reg == lphs_pkg::MODE_ADD)
                        begin
                            res_status_next = lphs_pkg::ST_PRESENT;
                        end
                        else
                        begin
                            wr_req.en       = 1'b1;
                            wr_req.mark     = lphs_pkg::MARK_TOMB;
                            res_status_next = lphs_pkg::ST_DELETED;
                        end
                    end
                    else if ((rd_data.mark == lphs_pkg::MARK_NEVER) || chk_last_reg)
                    begin
                        chk_valid_next = 1'b0;
                        state_next     = S_DONE;
                        if ((mode_reg == lphs_pkg::MODE_ADD) && ins_ok)
                        begin
                            wr_req.en       = 1'b1;
                            wr_req.key_en   = 1'b1;
                            wr_req.slot     = ins_slot;
                            res_status_next = lphs_pkg::ST_INSERTED;
                            res_slot_next   = ins_slot;
                        end
                        else if (mode_reg == lphs_pkg::MODE_ADD)
                        begin
                            res_status_next = lphs_pkg::ST_FULL;
                            res_slot_next   = '0;
                        end
                        else
                        begin
                            res_status_next = lphs_pkg::ST_NOT_FOUND;
                            res_slot_next   = '0;
                        end
                    end
                    else
                    begin
                        // Keep probing
                    end
                end
            end

            S_DONE:
            begin
                // Hand over once the output register is free
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_slot_next   = res_slot_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            mode_reg       <= 1'b0;
            key_reg        <= '0;
            len_reg        <= '0;
            iss_slot_reg   <= '0;
            iss_cnt_reg    <= '0;
            chk_valid_reg  <= 1'b0;
            chk_slot_reg   <= '0;
            chk_last_reg   <= 1'b0;
            free_hit_reg   <= 1'b0;
            free_slot_reg  <= '0;
            res_status_reg <= lphs_pkg::ST_INSERTED;
            res_slot_reg   <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= lphs_pkg::ST_INSERTED;
            out_slot_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            mode_reg       <= mode_next;
            key_reg        <= key_next;
            len_reg        <= len_next;
            iss_slot_reg   <= iss_slot_next;
            iss_cnt_reg    <= iss_cnt_next;
            chk_valid_reg  <= chk_valid_next;
            chk_slot_reg   <= chk_slot_next;
            chk_last_reg   <= chk_last_next;
            free_hit_reg   <= free_hit_next;
            free_slot_reg  <= free_slot_next;
            res_status_reg <= res_status_next;
            res_slot_reg   <= res_slot_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_slot_reg   <= out_slot_next;
        end
    end

    assign req.ready      = (state_reg == S_IDLE);
    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.slot_index = out_slot_reg[lphs_pkg::SLOT_OUT_W-1:0];

endmodule
